FILE: rtl/blsws_pkg.sv
// ----------------------------------------------------------------------------
// blsws_pkg: shared definitions for the bounded list store
// Types, codes and default sizes used by the cells, the divider and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package blsws_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SORT   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_MARK,
        OP_PROP,
        OP_SHIFT,
        OP_ROTATE,
        OP_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROP,
        ST_SHIFT,
        ST_SORT,
        ST_STATS,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/blsws_cell.sv
// ----------------------------------------------------------------------------
// blsws_cell: one list position
// Holds one entry and a match flag, and trades data with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module blsws_cell
    import blsws_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [CW-1:0]      count,
    input  wire logic signed [31:0] value,
    input  wire logic signed [31:0] prev_data,
    input  wire logic               prev_mark,
    input  wire logic signed [31:0] next_data,
    output logic signed [31:0]      data,
    output logic                    mark
);

    logic signed [31:0] data_reg, data_next;
    logic               m_reg, m_next;
    logic               p_reg, p_next;
    logic               own_valid, next_valid, is_left, is_right;

    assign own_valid  = CW'(IDX) < count;
    assign next_valid = CW'(IDX + 1) < count;
    assign is_left    = (IDX % 2 == 0) ? !ctrl.phase : ctrl.phase;
    assign is_right   = (IDX >= 1) && !is_left;

    always_comb begin
        data_next = data_reg;
        m_next    = m_reg;
        p_next    = p_reg;
        case (ctrl.op)
            OP_LOAD: begin
                if (CW'(IDX) == count) begin
                    data_next = value;
                end
            end
            OP_MARK: begin
                m_next = own_valid && (data_reg == value);
                p_next = 1'b0;
            end
            OP_PROP: begin
                p_next = prev_mark;
            end
            OP_SHIFT: begin
                if ((p_reg || m_reg) && next_valid) begin
                    data_next = next_data;
                end
            end
            OP_ROTATE: begin
                data_next = next_data;
            end
            OP_SORT: begin
                if (is_left && next_valid && (next_data < data_reg)) begin
                    data_next = next_data;
                end else if (is_right && own_valid && (prev_data > data_reg)) begin
                    data_next = prev_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            m_reg <= 1'b0;
            p_reg <= 1'b0;
        end else begin
            m_reg <= m_next;
            p_reg <= p_next;
        end
    end

    assign data = data_reg;
    assign mark = p_reg || m_reg;

endmodule

`default_nettype wire

FILE: rtl/blsws_div.sv
// ----------------------------------------------------------------------------
// blsws_div: signed sum over entry count
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module blsws_div
    import blsws_pkg::*;
#(
    parameter int CW = 7,
    parameter int SW = 39
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [SW-1:0] dividend,
    input  wire logic [CW-1:0]      divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    localparam int BW = $clog2(SW + 1);

    logic [CW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quo_reg, quo_next;
    logic [CW-1:0] div_reg;
    logic          neg_reg;
    logic [BW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [CW:0]   trial;
    logic [SW-1:0] signed_q;

    assign trial = {rem_reg, quo_reg[SW-1]};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[SW-1] ? (~dividend + 1'b1) : dividend;
            bit_next  = BW'(SW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = CW'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end else begin
                rem_next = trial[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            bit_next = bit_reg - 1'b1;
            if (bit_reg == BW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        if (start) begin
            div_reg <= divisor;
            neg_reg <= dividend[SW-1];
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign signed_q = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign done     = done_reg;
    assign quotient = signed_q[31:0];

endmodule

`default_nettype wire

FILE: rtl/bounded_list_store_with_stats.sv
// ----------------------------------------------------------------------------
// bounded_list_store_with_stats: ordered list with min, max and average
// Row of entry cells with a small sequencer and an iterative divider.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser carries the kind (insert,
// delete, sort) and s_tdata the value. Each request yields one result on
// the m_ channel with the status in m_tuser and the count and statistics
// in m_tdata. One request is handled at a time; s_tready is high only
// between requests.
// The accepting cycle stores an insert or marks the matches of a delete.
// A delete then lets the match prefix travel along the cell row, and the
// row then closes the gap; a sort runs odd-even exchange between neighbor
// cells. The statistics then rotate the row once, and the average comes
// from the bit-serial divider, skipped when the list is empty. The result
// is held until m_tready is high; the next request is taken the cycle
// after. Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_store_with_stats
    import blsws_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // value[31:0]
    input  wire logic [1:0]   s_tuser,   // kind[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // entry_count[6:0], smallest, largest, average, pad
    output logic [1:0]        m_tuser    // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = 32 + CW;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [1:0]    status_reg, status_next;
    logic signed [31:0] value_reg;
    logic signed [31:0] lo_reg, lo_next, hi_reg, hi_next, avg_reg;
    logic signed [SW-1:0] sum_reg, sum_next;
    cell_ctrl_t ctrl;
    logic accept, last_step, div_start, div_done;
    logic signed [31:0] quotient, head;
    logic signed [31:0] data_w [CAPACITY];
    logic               mark_w [CAPACITY];
    logic [CW+6:0]      count_ext;

    assign accept    = s_tvalid && s_tready;
    assign last_step = step_reg == CW'(CAPACITY - 1);
    assign head      = data_w[0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            blsws_cell #(.IDX(gi), .CW(CW)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .count     (count_reg),
                .value     (accept ? $signed(s_tdata) : value_reg),
                .prev_data ((gi == 0) ? 32'sd0 : data_w[(gi + CAPACITY - 1) % CAPACITY]),
                .prev_mark ((gi == 0) ? 1'b0 : mark_w[(gi + CAPACITY - 1) % CAPACITY]),
                .next_data (data_w[(gi + 1) % CAPACITY]),
                .data      (data_w[gi]),
                .mark      (mark_w[gi])
            );
        end
    endgenerate

    blsws_div #(.CW(CW), .SW(SW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_DELETE && count_reg != '0) begin
                        state_next = ST_PROP;
                    end else if (s_tuser == KIND_SORT) begin
                        state_next = ST_SORT;
                    end else begin
                        state_next = ST_STATS;
                    end
                end
            end
            ST_PROP:  state_next = last_step ? ST_SHIFT : ST_PROP;
            ST_SHIFT: state_next = ST_STATS;
            ST_SORT:  state_next = last_step ? ST_STATS : ST_SORT;
            ST_STATS: begin
                if (last_step) begin
                    state_next = (count_reg == '0) ? ST_OUT : ST_DIVGO;
                end
            end
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV:   state_next = div_done ? ST_OUT : ST_DIV;
            ST_OUT:   state_next = m_tready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.op    = OP_HOLD;
        ctrl.phase = step_reg[0];
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == KIND_INSERT) begin
                    ctrl.op = OP_LOAD;
                end else if (accept && s_tuser == KIND_DELETE) begin
                    ctrl.op = OP_MARK;
                end
            end
            ST_PROP:  ctrl.op = OP_PROP;
            ST_SHIFT: ctrl.op = OP_SHIFT;
            ST_SORT:  ctrl.op = OP_SORT;
            ST_STATS: ctrl.op = OP_ROTATE;
            ST_DIVGO: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        step_next   = '0;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sum_next    = sum_reg;
        if (state_reg == ST_IDLE && accept) begin
            status_next = STAT_OK;
            lo_next     = '0;
            hi_next     = '0;
            sum_next    = '0;
            if (s_tuser == KIND_INSERT) begin
                if (count_reg < CW'(CAPACITY)) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    status_next = STAT_FULL;
                end
            end else if (s_tuser == KIND_DELETE && count_reg == '0) begin
                status_next = STAT_EMPTY;
            end
        end
        if (state_reg == ST_PROP || state_reg == ST_SORT || state_reg == ST_STATS) begin
            step_next = last_step ? '0 : step_reg + 1'b1;
        end
        if (state_reg == ST_SHIFT) begin
            if (mark_w[CAPACITY-1]) begin
                count_next = count_reg - 1'b1;
            end else begin
                status_next = STAT_NOT_FOUND;
            end
        end
        if (state_reg == ST_STATS && step_reg < count_reg) begin
            sum_next = sum_reg + SW'(head);
            if (step_reg == '0 || head < lo_reg) begin
                lo_next = head;
            end
            if (step_reg == '0 || head > hi_reg) begin
                hi_next = head;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sum_reg <= sum_next;
        if (accept) begin
            value_reg <= $signed(s_tdata);
            avg_reg   <= '0;
        end else if (div_done) begin
            avg_reg <= quotient;
        end
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            status_reg <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            status_reg <= status_next;
        end
    end

    assign count_ext = {7'd0, count_reg};
    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = state_reg == ST_OUT;
    assign m_tuser   = status_reg;
    assign m_tdata   = {1'b0, avg_reg, hi_reg, lo_reg, count_ext[6:0]};

endmodule

`default_nettype wire

FILE: tb/sv/bounded_list_store_with_stats_test.sv
// ----------------------------------------------------------------------------
// bounded_list_store_with_stats_test: request and result check of the list store
// Drives insert, delete, sort and unused-kind requests, predicts every result from a
// model of the list kept here, and compares each field of each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_store_with_stats_test;
    import blsws_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] average;
        logic [31:0] largest;
        logic [31:0] smallest;
        logic [6:0]  entry_count;
    } list_result_t;

    class list_scoreboard;
        logic signed [31:0] list_vals[$];
        list_result_t       pending[$];
        int                 errors;

        function void note_request(logic [1:0] kind, logic signed [31:0] value);
            list_result_t       r;
            logic signed [63:0] sum;
            logic signed [31:0] t;
            int                 idx;
            r = '0;
            r.status = STAT_OK;
            if (kind == KIND_INSERT) begin
                if (list_vals.size() >= CAP) r.status = STAT_FULL;
                else list_vals.push_back(value);
            end else if (kind == KIND_DELETE) begin
                if (list_vals.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    idx = -1;
                    for (int i = 0; i < list_vals.size(); i++)
                        if (idx < 0 && list_vals[i] == value) idx = i;
                    if (idx < 0) r.status = STAT_NOT_FOUND;
                    else list_vals.delete(idx);
                end
            end else if (kind == KIND_SORT) begin
                for (int p = 1; p < list_vals.size(); p++)
                    for (int k = 0; k + 1 < list_vals.size(); k++)
                        if (list_vals[k] > list_vals[k+1]) begin
                            t = list_vals[k];
                            list_vals[k] = list_vals[k+1];
                            list_vals[k+1] = t;
                        end
            end
            r.entry_count = 7'(list_vals.size());
            if (list_vals.size() > 0) begin
                r.smallest = list_vals[0];
                r.largest = list_vals[0];
                sum = 0;
                foreach (list_vals[i]) begin
                    if (list_vals[i] < $signed(r.smallest)) r.smallest = list_vals[i];
                    if (list_vals[i] > $signed(r.largest)) r.largest = list_vals[i];
                    sum += 64'(list_vals[i]);
                end
                r.average = 32'(sum / $signed(64'(list_vals.size())));
            end
            pending.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status expected %0d got %0d", e.status, got.status); errors++;
            end
            if (got.entry_count !== e.entry_count) begin
                $error("entry_count expected %0d got %0d", e.entry_count, got.entry_count);
                errors++;
            end
            if (got.smallest !== e.smallest) begin
                $error("smallest expected %0d got %0d", $signed(e.smallest),
                       $signed(got.smallest)); errors++;
            end
            if (got.largest !== e.largest) begin
                $error("largest expected %0d got %0d", $signed(e.largest),
                       $signed(got.largest)); errors++;
            end
            if (got.average !== e.average) begin
                $error("average expected %0d got %0d", $signed(e.average),
                       $signed(got.average)); errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    list_scoreboard board = new();
    int send_idle = 19;
    int recv_idle = 72;
    int hold_cycles = 0;
    bit sending_done = 0;

    bounded_list_store_with_stats i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_request(logic [1:0] kind, logic [31:0] value);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        board.note_request(kind, value);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $signed($urandom_range(20)) - 10;
            2: v = 32'h7FFFFFFF - $urandom_range(3);
            3: v = 32'h80000000 + $urandom_range(3);
            default: v = (board.list_vals.size() > 0) ?
                board.list_vals[$urandom_range(board.list_vals.size() - 1)] : $urandom;
        endcase
        return v;
    endfunction

    task automatic send_random(int n, int ins_weight);
        int r;
        logic [1:0] kind;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < ins_weight) kind = KIND_INSERT;
            else if (r < 92) kind = KIND_DELETE;
            else if (r < 98) kind = KIND_SORT;
            else kind = KIND_UNUSED;
            send_request(kind, pick_value());
        end
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result({m_tuser, m_tdata[102:0]});
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_request(KIND_DELETE, 32'd5);
        send_request(KIND_SORT, 32'd0);
        send_request(KIND_UNUSED, 32'hFFFFFFFF);
        send_request(KIND_INSERT, 32'h7FFFFFFF);
        send_request(KIND_SORT, 32'd0);
        send_request(KIND_INSERT, 32'h7FFFFFFF);
        send_request(KIND_INSERT, 32'h80000000);
        send_request(KIND_INSERT, 32'hFFFFFFFF);
        send_request(KIND_INSERT, 32'h80000000);
        send_request(KIND_DELETE, 32'd12345);
        send_request(KIND_DELETE, 32'h7FFFFFFF);
        send_request(KIND_SORT, 32'd0);
        send_request(KIND_DELETE, 32'h80000000);
        send_request(KIND_INSERT, 32'h55555555);
        send_request(KIND_INSERT, 32'hAAAAAAAA);
        send_request(KIND_UNUSED, 32'd0);
        send_request(KIND_DELETE, 32'h80000000);
        for (int i = 0; i < CAP + 2; i++) send_request(KIND_INSERT, $urandom);
        send_request(KIND_SORT, 32'd0);
        hold_cycles = 3000;
        send_random(30, 60);
        send_idle = 19;
        recv_idle = 72;
        send_random(500, 55);
        send_idle = 72;
        recv_idle = 19;
        send_random(500, 45);
        send_idle = 0;
        recv_idle = 0;
        send_random(500, 50);
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("bounded_list_store_with_stats_test passed");
        else
            $display("bounded_list_store_with_stats_test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("bounded_list_store_with_stats_test failed");
        $finish;
    end

endmodule

`default_nettype wire
